// File: rtl/irsfp_pkg.sv
// Shared constants, types and status codes for the sensor frame parser.
package irsfp_pkg;

  localparam int CHANNELS     = 8;
  localparam int BUFFER_BYTES = 200;
  localparam int FRAME_LIMIT  = 60;
  localparam int OUT_CHANS    = 8;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = $clog2(BUFFER_BYTES);
  localparam int LEN_W    = $clog2(FRAME_LIMIT + 1);
  localparam int IDX_W    = $clog2(CHANNELS + 1);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STAT_W   = 2;
  localparam int UPD_W    = 4;

  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_TAG   = 8'h44;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_X     = 8'h78;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

  localparam logic [STAT_W-1:0] ST_NO_START = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_TAG  = 2'd2;
  localparam logic [STAT_W-1:0] ST_PARSED   = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic feed;
    logic close_zero;
    logic close_end;
    logic clear;
  } tok_ctl_t;

  typedef struct packed {
    logic  push;
    byte_t value;
  } tok_res_t;

endpackage

// File: rtl/irsfp_token.sv
// Token tracker: follows one comma-separated token and yields its value on close.
module irsfp_token (
  input  logic                clk,
  input  logic                rst,
  input  irsfp_pkg::tok_ctl_t ctl,
  input  irsfp_pkg::byte_t    data,
  output irsfp_pkg::tok_res_t res
);
  import irsfp_pkg::*;

  logic  has_x;
  logic  colon_seen;
  logic  char_taken;
  byte_t captured;

  logic  has_x_step;
  logic  colon_step;
  logic  taken_step;
  byte_t captured_step;
  logic  comma_close;
  logic  any_close;
  logic  src_x;
  logic  src_colon;
  byte_t src_captured;

  always_comb begin
    has_x_step    = has_x;
    colon_step    = colon_seen;
    taken_step    = char_taken;
    captured_step = captured;
    comma_close   = ctl.feed && (data == CH_COMMA);
    if (ctl.feed && !comma_close) begin
      if (data == CH_X) begin
        has_x_step = 1'b1;
      end
      if (colon_seen) begin
        if (!char_taken) begin
          captured_step = data;
          taken_step    = 1'b1;
        end
      end else if (data == CH_COLON) begin
        colon_step = 1'b1;
      end
    end
    any_close = comma_close || ctl.close_zero || ctl.close_end;
    if (ctl.close_end) begin
      src_x        = has_x_step;
      src_colon    = colon_step;
      src_captured = captured_step;
    end else begin
      src_x        = has_x;
      src_colon    = colon_seen;
      src_captured = captured;
    end
    res.push  = any_close && src_x && src_colon;
    res.value = src_captured - CH_ZERO;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear || any_close) begin
      has_x      <= 1'b0;
      colon_seen <= 1'b0;
      char_taken <= 1'b0;
      captured   <= '0;
    end else begin
      has_x      <= has_x_step;
      colon_seen <= colon_step;
      char_taken <= taken_step;
      captured   <= captured_step;
    end
  end

endmodule

// File: rtl/ir_sensor_frame_parser.sv
// Top level of the eight-channel sensor frame parser.
// A '#' word accepted while the buffer is not full has its result registered for the next cycle.
// Throughput: one received word per cycle; input stalls only while a result is held
// in the output register and the receiver stalls it.
// Reset clears the byte count, frame and token state, the stored channel values
// and the output valid; no clearing pass is needed.
module ir_sensor_frame_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rx_valid,
  output logic                          rx_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [1:0]                    frame_status,
  output logic [3:0]                    values_updated,
  output logic [7:0]                    chan0,
  output logic [7:0]                    chan1,
  output logic [7:0]                    chan2,
  output logic [7:0]                    chan3,
  output logic [7:0]                    chan4,
  output logic [7:0]                    chan5,
  output logic [7:0]                    chan6,
  output logic [7:0]                    chan7
);
  import irsfp_pkg::*;

  logic [CNT_W-1:0]  stored_count;
  logic              start_seen;
  logic [LEN_W-1:0]  frame_length;
  logic              tag_ok;
  logic              text_ended;
  logic [IDX_W-1:0]  pending_index;
  byte_t             pending_values [CHANNELS];
  byte_t             channel_values [CHANNELS];
  logic [STAT_W-1:0] out_status;
  logic [UPD_W-1:0]  out_updated;
  byte_t             out_chan [OUT_CHANS];

  logic              accept;
  logic              full;
  logic              is_start;
  logic              is_end;
  logic              in_text;
  logic [CNT_W-1:0]  stored_count_next;
  logic              start_seen_next;
  logic [LEN_W-1:0]  frame_length_next;
  logic              tag_ok_next;
  logic              text_ended_next;
  logic [IDX_W-1:0]  pending_index_next;
  logic              pend_write;
  logic [CH_IDX_W-1:0] pend_addr;
  logic [STAT_W-1:0] status_next;
  logic              commit;
  byte_t             channel_next [CHANNELS];
  tok_ctl_t          tok_ctl;
  tok_res_t          tok_res;

  assign rx_stall = res_valid && res_stall;
  assign accept   = rx_valid && !rx_stall;
  assign full     = stored_count >= CNT_W'(BUFFER_BYTES - 1);
  assign is_start = !start_seen && (rx_byte == CH_START);
  assign is_end   = rx_byte == CH_END;
  assign in_text  = start_seen && !text_ended;
  assign pend_addr = pending_index[CH_IDX_W-1:0];

  always_comb begin
    tok_ctl.feed       = accept && !full && in_text && (rx_byte != CH_NUL);
    tok_ctl.close_zero = accept && !full && in_text && (rx_byte == CH_NUL);
    tok_ctl.close_end  = accept && !full && in_text && is_end;
    tok_ctl.clear      = accept && (full || is_end);
  end

  irsfp_token u_token (
    .clk  (clk),
    .rst  (rst),
    .ctl  (tok_ctl),
    .data (rx_byte),
    .res  (tok_res)
  );

  always_comb begin
    pend_write         = tok_res.push && (pending_index < IDX_W'(CHANNELS));
    pending_index_next = pend_write ? pending_index + IDX_W'(1) : pending_index;
    start_seen_next    = start_seen || is_start;
    tag_ok_next        = tag_ok ||
                         (start_seen && (frame_length == LEN_W'(1)) && (rx_byte == CH_TAG));
    text_ended_next    = text_ended || (in_text && (rx_byte == CH_NUL));
    if (start_seen) begin
      frame_length_next = (frame_length < LEN_W'(FRAME_LIMIT)) ?
                          frame_length + LEN_W'(1) : frame_length;
    end else if (is_start) begin
      frame_length_next = LEN_W'(1);
    end else begin
      frame_length_next = '0;
    end
    stored_count_next = stored_count + CNT_W'(1);

    if (!start_seen_next) begin
      status_next = ST_NO_START;
    end else if (frame_length_next >= LEN_W'(FRAME_LIMIT)) begin
      status_next = ST_TOO_LONG;
    end else if (!tag_ok_next) begin
      status_next = ST_BAD_TAG;
    end else begin
      status_next = ST_PARSED;
    end
    commit = is_end && (status_next == ST_PARSED);

    for (int i = 0; i < CHANNELS; i++) begin
      channel_next[i] = channel_values[i];
      if (commit && (IDX_W'(i) < pending_index_next)) begin
        if (pend_write && (IDX_W'(i) == pending_index)) begin
          channel_next[i] = tok_res.value;
        end else begin
          channel_next[i] = pending_values[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !full && pend_write) begin
      pending_values[pend_addr] <= tok_res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      start_seen    <= 1'b0;
      frame_length  <= '0;
      tag_ok        <= 1'b0;
      text_ended    <= 1'b0;
      pending_index <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        channel_values[i] <= '0;
      end
    end else if (accept) begin
      if (full || is_end) begin
        stored_count  <= '0;
        start_seen    <= 1'b0;
        frame_length  <= '0;
        tag_ok        <= 1'b0;
        text_ended    <= 1'b0;
        pending_index <= '0;
      end else begin
        stored_count  <= stored_count_next;
        start_seen    <= start_seen_next;
        frame_length  <= frame_length_next;
        tag_ok        <= tag_ok_next;
        text_ended    <= text_ended_next;
        pending_index <= pending_index_next;
      end
      if (!full) begin
        for (int i = 0; i < CHANNELS; i++) begin
          channel_values[i] <= channel_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && !full && is_end) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !full && is_end) begin
      out_status  <= status_next;
      out_updated <= commit ? UPD_W'(pending_index_next) : '0;
    end
  end

  for (genvar g = 0; g < OUT_CHANS; g++) begin : g_out
    if (g < CHANNELS) begin : g_live
      always_ff @(posedge clk) begin
        if (accept && !full && is_end) begin
          out_chan[g] <= channel_next[g];
        end
      end
    end else begin : g_unused
      assign out_chan[g] = '0;
    end
  end

  assign frame_status   = out_status;
  assign values_updated = out_updated;
  assign chan0 = out_chan[0];
  assign chan1 = out_chan[1];
  assign chan2 = out_chan[2];
  assign chan3 = out_chan[3];
  assign chan4 = out_chan[4];
  assign chan5 = out_chan[5];
  assign chan6 = out_chan[6];
  assign chan7 = out_chan[7];

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    pending_index <= IDX_W'(CHANNELS))
    else $error("pending index beyond channel count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(BUFFER_BYTES - 1))
    else $error("stored byte count beyond buffer");

  a_start_len: assert property (@(posedge clk) disable iff (rst)
    start_seen == (frame_length != '0))
    else $error("frame length disagrees with start flag");

  a_update_parsed: assert property (@(posedge clk) disable iff (rst)
    res_valid && (values_updated != '0) |-> frame_status == ST_PARSED)
    else $error("values updated on a frame that did not parse");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    accept && !full && is_end |=> res_valid)
    else $error("end mark gave no result");

endmodule

// File: dv/testbench.sv
// Testbench for the sensor frame parser: a frame predictor checks every result word.
module testbench;
  import irsfp_pkg::*;

  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [UPD_W-1:0] updated;
    logic [OUT_CHANS-1:0][BYTE_W-1:0] chans;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;
  logic rx_valid;
  logic rx_stall;
  logic [7:0] rx_byte;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [1:0] frame_status;
  logic [3:0] values_updated;
  logic [7:0] chan0, chan1, chan2, chan3, chan4, chan5, chan6, chan7;

  ir_sensor_frame_parser dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall),
    .frame_status(frame_status), .values_updated(values_updated),
    .chan0(chan0), .chan1(chan1), .chan2(chan2), .chan3(chan3),
    .chan4(chan4), .chan5(chan5), .chan6(chan6), .chan7(chan7)
  );

  always #5 clk = ~clk;

  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int frames_checked;
  int error_count;
  int idle_cycles;

  frame_result_t expected_frames[$];

  logic [CNT_W-1:0] stored_count;
  logic start_seen;
  logic [LEN_W-1:0] frame_len;
  logic tag_ok;
  logic text_ended;
  logic tok_has_x;
  logic tok_colon;
  logic tok_taken;
  byte_t tok_char;
  logic [IDX_W-1:0] pend_idx;
  byte_t pend_vals[CHANNELS];
  byte_t chan_vals[CHANNELS];

  function automatic void token_clear();
    tok_has_x = 1'b0;
    tok_colon = 1'b0;
    tok_taken = 1'b0;
    tok_char = '0;
  endfunction

  function automatic void frame_clear();
    stored_count = '0;
    start_seen = 1'b0;
    frame_len = '0;
    tag_ok = 1'b0;
    text_ended = 1'b0;
    pend_idx = '0;
    token_clear();
  endfunction

  function automatic void token_close();
    if (tok_has_x && tok_colon && pend_idx < CHANNELS) begin
      pend_vals[pend_idx[CH_IDX_W-1:0]] = tok_char - CH_ZERO;
      pend_idx = pend_idx + 1'b1;
    end
    token_clear();
  endfunction

  function automatic void token_feed(byte_t b);
    if (b == CH_COMMA) begin
      token_close();
    end else begin
      if (b == CH_X) tok_has_x = 1'b1;
      if (tok_colon) begin
        if (!tok_taken) begin
          tok_char = b;
          tok_taken = 1'b1;
        end
      end else if (b == CH_COLON) begin
        tok_colon = 1'b1;
      end
    end
  endfunction

  function automatic void parse_rx_word(byte_t b);
    frame_result_t res;
    if (stored_count >= BUFFER_BYTES - 1) begin
      frame_clear();
      return;
    end
    stored_count = stored_count + 1'b1;
    if (!start_seen) begin
      if (b == CH_START) begin
        start_seen = 1'b1;
        frame_len = LEN_W'(1);
        token_feed(b);
      end
    end else begin
      if (frame_len == 1 && b == CH_TAG) tag_ok = 1'b1;
      if (frame_len < FRAME_LIMIT) frame_len = frame_len + 1'b1;
      if (!text_ended) begin
        if (b == CH_NUL) begin
          token_close();
          text_ended = 1'b1;
        end else begin
          token_feed(b);
        end
      end
    end
    if (b != CH_END) return;
    if (start_seen && !text_ended) token_close();
    if (!start_seen) res.status = ST_NO_START;
    else if (frame_len >= FRAME_LIMIT) res.status = ST_TOO_LONG;
    else if (!tag_ok) res.status = ST_BAD_TAG;
    else res.status = ST_PARSED;
    res.updated = '0;
    if (res.status == ST_PARSED) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (i < pend_idx) chan_vals[i] = pend_vals[i];
      end
      res.updated = UPD_W'(pend_idx);
    end
    for (int i = 0; i < OUT_CHANS; i++) res.chans[i] = (i < CHANNELS) ? chan_vals[i] : '0;
    expected_frames.push_back(res);
    frame_clear();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("Mismatch on %s at %0t: got %0d, expected %0d.", what, $realtime, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    frame_result_t got_res;
    frame_result_t want_res;
    if (!rst && res_valid && !res_stall) begin
      got_res.status = frame_status;
      got_res.updated = values_updated;
      got_res.chans = {chan7, chan6, chan5, chan4, chan3, chan2, chan1, chan0};
      if (expected_frames.size() == 0) begin
        $display("Unexpected result word at %0t.", $realtime);
        error_count++;
      end else begin
        want_res = expected_frames.pop_front();
        frames_checked++;
        if (got_res.status != want_res.status)
          report_mismatch("frame_status", got_res.status, want_res.status);
        if (got_res.updated != want_res.updated)
          report_mismatch("values_updated", got_res.updated, want_res.updated);
        for (int i = 0; i < OUT_CHANS; i++) begin
          if (got_res.chans[i] != want_res.chans[i])
            report_mismatch($sformatf("chan%0d", i), got_res.chans[i], want_res.chans[i]);
        end
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(byte_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      rx_byte <= byte_t'($urandom_range(255));
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    parse_rx_word(b);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(byte_t'(s[i]));
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    rx_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  function automatic byte_t text_byte();
    byte_t b;
    do b = byte_t'($urandom_range(255)); while (b == CH_END || b == CH_NUL);
    return b;
  endfunction

  function automatic byte_t digit_byte();
    return CH_ZERO + byte_t'($urandom_range(9));
  endfunction

  task automatic test_special_frames();
    send_word(8'h00);
    send_word(8'hFF);
    send_text("#");
    send_text("$D#");
    send_text("$D,x3:9,:x,x:,,x1:#");
    send_text("$E,x1:1#");
    send_text("$D$,x1:2#");
    send_text("$D,x1:7");
    send_word(CH_NUL);
    send_text(",x2:3#");
    send_text("$D,x:");
    send_word(8'hFF);
    send_word(CH_END);
    send_text("$D,x1:1,x2:2,x3:3,x4:4,x5:5,x6:6,x7:7,x8:8,x9:9#");
  endtask

  task automatic test_frame_limit();
    int lens[3] = '{FRAME_LIMIT - 1, FRAME_LIMIT, FRAME_LIMIT + 10};
    foreach (lens[k]) begin
      send_text("$D,x1:9");
      repeat (lens[k] - 8) send_word("a");
      send_word(CH_END);
    end
  endtask

  task automatic test_buffer_full();
    repeat (BUFFER_BYTES - 1) send_word(8'h61 + byte_t'($urandom_range(25)));
    send_word(CH_START);
    send_text("$D,x4:4#");
    repeat (BUFFER_BYTES - 10) send_word(8'h61 + byte_t'($urandom_range(25)));
    send_text("$D,x1:1,x2:2#");
  endtask

  task automatic send_random_frame();
    int kind;
    int ntok;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) send_word(byte_t'($urandom_range(255)));
    end else begin
      if (kind < 12) send_word(text_byte());
      send_word(CH_START);
      send_word(($urandom_range(9) == 0) ? text_byte() : CH_TAG);
      ntok = $urandom_range(11);
      for (int t = 0; t < ntok; t++) begin
        send_word(CH_COMMA);
        case ($urandom_range(9))
          0: ;
          1: repeat ($urandom_range(1, 4)) send_word(text_byte());
          2: begin
            send_word(CH_X);
            send_word(digit_byte());
          end
          3: begin
            send_word(CH_COLON);
            send_word(digit_byte());
          end
          4: begin
            send_word(CH_X);
            send_word(digit_byte());
            send_word(CH_COLON);
          end
          default: begin
            send_word(CH_X);
            send_word(digit_byte());
            send_word(CH_COLON);
            send_word(($urandom_range(3) == 0) ? text_byte() : digit_byte());
            if ($urandom_range(7) == 0) send_word(text_byte());
          end
        endcase
        if ($urandom_range(39) == 0) send_word(CH_NUL);
      end
      if ($urandom_range(11) == 0) repeat ($urandom_range(20, 60)) send_word(text_byte());
      send_word(CH_END);
    end
  endtask

  task automatic test_random_frames(int n, bit with_pause);
    int stop;
    int half;
    bit paused;
    stop = words_sent + n;
    half = words_sent + n / 2;
    paused = 1'b0;
    while (words_sent < stop) begin
      send_random_frame();
      if (with_pause && !paused && words_sent >= half) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_valid = 1'b0;
    rx_byte = '0;
    send_idle_pct = 16;
    recv_stall_pct = 84;
    words_sent = 0;
    frames_checked = 0;
    error_count = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      pend_vals[i] = '0;
      chan_vals[i] = '0;
    end
    frame_clear();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_special_frames();
    test_frame_limit();
    test_buffer_full();
    test_random_frames(270, 1'b1);
    send_idle_pct = 84;
    recv_stall_pct = 16;
    test_random_frames(270, 1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_frames(270, 1'b0);

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $display("%0d expected results never arrived.", expected_frames.size());
      error_count++;
    end
    $display("Sent %0d received words and checked %0d frame results under three idle mixes.",
             words_sent, frames_checked);
    $display("Covered bad tags, long frames, buffer overflow, zero bytes and extra values.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
